/* src/nfcs_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and constants of the NOR flash command sequencer.
package nfcs_pkg;

	localparam int ADDR_W    = 19;
	localparam int DATA_W    = 8;
	localparam int HDATA_W   = 16;
	localparam int CMD_W     = 3;
	localparam int KIND_W    = 2;
	localparam int STATUS_W  = 2;
	localparam int PL_W      = 14;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = PADDR_W - 2;

	localparam int ADDRESS_BITS_DEFAULT = 19;
	localparam int QUEUE_DEPTH_DEFAULT  = 4;

	localparam logic [PL_W-1:0] POLL_LIMIT_RESET = 14'd10000;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_POLL_LIMIT = 1'b0;

	// host commands
	localparam logic [CMD_W-1:0] CMD_PROGRAM = 3'd0;
	localparam logic [CMD_W-1:0] CMD_ERASE   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_READ_ID = 3'd2;
	localparam logic [CMD_W-1:0] CMD_READ    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_RETURN  = 3'd4;

	// fixed unlock addresses and command bytes
	localparam logic [ADDR_W-1:0] UNLOCK_ADDR_A = 19'h05555;
	localparam logic [ADDR_W-1:0] UNLOCK_ADDR_B = 19'h02AAA;
	localparam logic [DATA_W-1:0] BYTE_UNLOCK_A = 8'hAA;
	localparam logic [DATA_W-1:0] BYTE_UNLOCK_B = 8'h55;
	localparam logic [DATA_W-1:0] BYTE_PROGRAM  = 8'hA0;
	localparam logic [DATA_W-1:0] BYTE_ERASE    = 8'h80;
	localparam logic [DATA_W-1:0] BYTE_CHIP_ERS = 8'h10;
	localparam logic [DATA_W-1:0] BYTE_ID_ENTRY = 8'h90;
	localparam logic [DATA_W-1:0] BYTE_ID_EXIT  = 8'hF0;
	localparam logic [DATA_W-1:0] BYTE_ERASED   = 8'hFF;

	typedef enum logic [KIND_W-1:0] {
		KIND_WRITE  = 2'd0,
		KIND_READ   = 2'd1,
		KIND_REPORT = 2'd2
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE    = 2'd0,
		ST_TIMEOUT = 2'd1,
		ST_SKIPPED = 2'd2,
		ST_DATA    = 2'd3
	} status_t;

	// bus sequences the back end knows how to play out
	typedef enum logic [2:0] {
		OP_PROGRAM  = 3'd0,
		OP_ERASE    = 3'd1,
		OP_ID_ENTRY = 3'd2,
		OP_READ     = 3'd3,
		OP_REPORT   = 3'd4,
		OP_ID_EXIT  = 3'd5
	} job_op_t;

	typedef struct packed {
		job_op_t              op;
		logic [ADDR_W-1:0]    addr;
		logic [DATA_W-1:0]    data;
		status_t              status;
		logic [HDATA_W-1:0]   hdata;
	} job_t;

endpackage

/* src/nfcs_if.sv */
`timescale 1ns / 1ps
// Stream interfaces for host/flash-return items and for bus cycles/reports.
interface nfcs_req_if;
	import nfcs_pkg::*;

	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    command;
	logic [ADDR_W-1:0]   address;
	logic [DATA_W-1:0]   data;

	modport source (output valid, command, address, data, input ready);
	modport sink   (input valid, command, address, data, output ready);
endinterface

interface nfcs_rsp_if;
	import nfcs_pkg::*;

	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [ADDR_W-1:0]   bus_address;
	logic [DATA_W-1:0]   bus_data;
	logic [STATUS_W-1:0] status;
	logic [HDATA_W-1:0]  host_data;
	logic                last;

	modport source (output valid, kind, bus_address, bus_data, status, host_data, last,
		input ready);
	modport sink   (input valid, kind, bus_address, bus_data, status, host_data, last,
		output ready);
endinterface

/* src/nor_flash_command_sequencer.sv */
`timescale 1ns / 1ps
// Top level of the parallel NOR flash command sequencer.
//
// Usage:
//   req carries host commands (program byte, chip erase, read id, read byte)
//   and flash read data returns (command 4). rsp carries the results: bus
//   write cycles, bus read requests and host reports; last marks the final
//   result caused by one req transfer.
//   poll_limit is written over the APB port at byte address 0 while idle.
// Flow and throughput:
//   The front end takes one req transfer per clock whenever the 4-entry job
//   queue has room, and decides that item's phase and polling at once.
//   The back end sequencer emits one result per clock while rsp is not
//   stalled; an item yields 1 to 7 results (program 5, erase 7, read id
//   4, id exit 4, others 1), and that sequencer sets the sustained rate.
//   An item's first result passes the job queue, then the output register.
// Stalls and reset:
//   With rsp.ready low the output register holds; the queue keeps taking
//   items until full, then req.ready drops. Reset empties the queue, returns
//   the phase to idle and loads poll_limit with 10000.
module nor_flash_command_sequencer #(
	parameter int ADDRESS_BITS = nfcs_pkg::ADDRESS_BITS_DEFAULT,
	parameter int QUEUE_DEPTH  = nfcs_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	nfcs_req_if.sink                      req,
	nfcs_rsp_if.source                    rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [nfcs_pkg::PADDR_W-1:0]  paddr,
	input  logic [nfcs_pkg::PDATA_W-1:0]  pwdata,
	output logic [nfcs_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import nfcs_pkg::*;

	logic [PL_W-1:0]       poll_limit_q;
	logic                  reg_hit;
	logic                  q_full;
	logic                  q_push;
	logic                  q_pop;
	logic                  q_head_valid;
	job_t                  q_push_job;
	job_t                  q_head_job;

	// register file: a single poll limit register
	assign pready  = 1'b1;
	assign reg_hit = paddr[PADDR_W-1:2] == REG_POLL_LIMIT;
	assign prdata  = reg_hit ? PDATA_W'(poll_limit_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_limit_q <= POLL_LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			poll_limit_q <= pwdata[PL_W-1:0];
		end
	end

	// classify items and keep the command phase
	nfcs_front #(
		.ADDRESS_BITS (ADDRESS_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.poll_limit (poll_limit_q),
		.queue_full (q_full),
		.push       (q_push),
		.push_job   (q_push_job)
	);

	// decouples the front end from the slow bus sequence
	nfcs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_job   (q_push_job),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head_job   (q_head_job)
	);

	// expand jobs into bus cycles and reports
	nfcs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_head_valid),
		.head_job   (q_head_job),
		.pop        (q_pop),
		.rsp        (rsp)
	);

endmodule

/* src/nfcs_front.sv */
`timescale 1ns / 1ps
// Front end: takes items, tracks the command phase and polling, queues bus jobs.
module nfcs_front #(
	parameter int ADDRESS_BITS = nfcs_pkg::ADDRESS_BITS_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	nfcs_req_if.sink                    req,
	input  logic [nfcs_pkg::PL_W-1:0]   poll_limit,
	input  logic                        queue_full,
	output logic                        push,
	output nfcs_pkg::job_t              push_job
);
	import nfcs_pkg::*;

	localparam int AW = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
	localparam logic [ADDR_W-1:0] ADDR_MASK = ADDR_W'((64'd1 << AW) - 64'd1);

	typedef enum logic [2:0] {
		PH_IDLE, PH_PROG, PH_ERASE, PH_ID1, PH_ID2, PH_READ
	} phase_t;

	phase_t              phase_q, phase_d;
	logic [PL_W-1:0]     polls_left_q, polls_left_d;
	logic [ADDR_W-1:0]   poll_addr_q, poll_addr_d;
	logic                exp_top_q, exp_top_d;
	logic [DATA_W-1:0]   first_id_q, first_id_d;
	logic                accept;
	logic [ADDR_W-1:0]   addr_m;
	logic [PL_W-1:0]     limit_eff;

	assign req.ready = !queue_full;
	assign accept    = req.valid && req.ready;
	assign addr_m    = req.address & ADDR_MASK;
	assign limit_eff = (poll_limit == '0) ? PL_W'(1) : poll_limit;

	always_comb begin
		phase_d      = phase_q;
		polls_left_d = polls_left_q;
		poll_addr_d  = poll_addr_q;
		exp_top_d    = exp_top_q;
		first_id_d   = first_id_q;
		push         = 1'b0;
		push_job     = '0;
		if (accept) begin
			if (req.command == CMD_RETURN) begin
				case (phase_q)
					PH_PROG, PH_ERASE: begin
						push = 1'b1;
						if (req.data[DATA_W-1] == exp_top_q) begin
							push_job.op     = OP_REPORT;
							push_job.status = ST_DONE;
							phase_d         = PH_IDLE;
						end else if (polls_left_q <= PL_W'(1)) begin
							polls_left_d    = '0;
							push_job.op     = OP_REPORT;
							push_job.status = ST_TIMEOUT;
							phase_d         = PH_IDLE;
						end else begin
							polls_left_d  = polls_left_q - PL_W'(1);
							push_job.op   = OP_READ;
							push_job.addr = poll_addr_q;
						end
					end
					PH_ID1: begin
						push          = 1'b1;
						first_id_d    = req.data;
						push_job.op   = OP_READ;
						push_job.addr = ADDR_W'(1);
						phase_d       = PH_ID2;
					end
					PH_ID2: begin
						push            = 1'b1;
						push_job.op     = OP_ID_EXIT;
						push_job.status = ST_DATA;
						push_job.hdata  = {first_id_q, req.data};
						phase_d         = PH_IDLE;
					end
					PH_READ: begin
						push            = 1'b1;
						push_job.op     = OP_REPORT;
						push_job.status = ST_DATA;
						push_job.hdata  = {{(HDATA_W-DATA_W){1'b0}}, req.data};
						phase_d         = PH_IDLE;
					end
					default: begin
					end
				endcase
			end else if (phase_q == PH_IDLE) begin
				case (req.command)
					CMD_PROGRAM: begin
						push = 1'b1;
						if (req.data == BYTE_ERASED) begin
							push_job.op     = OP_REPORT;
							push_job.status = ST_SKIPPED;
						end else begin
							push_job.op   = OP_PROGRAM;
							push_job.addr = addr_m;
							push_job.data = req.data;
							poll_addr_d   = addr_m;
							exp_top_d     = req.data[DATA_W-1];
							polls_left_d  = limit_eff;
							phase_d       = PH_PROG;
						end
					end
					CMD_ERASE: begin
						push         = 1'b1;
						push_job.op  = OP_ERASE;
						poll_addr_d  = '0;
						exp_top_d    = 1'b1;
						polls_left_d = limit_eff;
						phase_d      = PH_ERASE;
					end
					CMD_READ_ID: begin
						push        = 1'b1;
						push_job.op = OP_ID_ENTRY;
						phase_d     = PH_ID1;
					end
					CMD_READ: begin
						push          = 1'b1;
						push_job.op   = OP_READ;
						push_job.addr = addr_m;
						phase_d       = PH_READ;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			polls_left_q <= '0;
			poll_addr_q  <= '0;
			exp_top_q    <= 1'b0;
			first_id_q   <= '0;
		end else begin
			phase_q      <= phase_d;
			polls_left_q <= polls_left_d;
			poll_addr_q  <= poll_addr_d;
			exp_top_q    <= exp_top_d;
			first_id_q   <= first_id_d;
		end
	end

	// a poll phase always has at least one read left
	a_polls_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PROG || phase_q == PH_ERASE) |-> polls_left_q != '0)
		else $error("poll phase with no polls left");

	// a stray data return while idle yields no job
	a_stray_return: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.command == CMD_RETURN && phase_q == PH_IDLE) |-> !push)
		else $error("job queued for stray return");

endmodule

/* src/nfcs_queue.sv */
`timescale 1ns / 1ps
// Short job queue between the front and back ends.
module nfcs_queue #(
	parameter int DEPTH = nfcs_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  nfcs_pkg::job_t  push_job,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output nfcs_pkg::job_t  head_job
);
	import nfcs_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t              mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_q, rd_q;
	logic [CNT_W-1:0]  count_q;

	assign full       = count_q == CNT_W'(DEPTH);
	assign head_valid = count_q != '0;
	assign head_job   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full job queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty job queue");

endmodule

/* src/nfcs_back.sv */
`timescale 1ns / 1ps
// Back end: plays each queued job out as bus cycles and reports, one per clock unless rsp stalls.
module nfcs_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  nfcs_pkg::job_t  head_job,
	output logic            pop,
	nfcs_rsp_if.source      rsp
);
	import nfcs_pkg::*;

	logic [2:0]          step_q;
	logic                load;
	kind_t               seq_kind;
	logic [ADDR_W-1:0]   seq_addr;
	logic [DATA_W-1:0]   seq_data;
	status_t             seq_status;
	logic [HDATA_W-1:0]  seq_hdata;
	logic                seq_last;

	logic                valid_q;
	kind_t               kind_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [DATA_W-1:0]   data_q;
	status_t             status_q;
	logic [HDATA_W-1:0]  hdata_q;
	logic                last_q;

	// one entry of the current job's bus sequence
	always_comb begin
		seq_kind   = KIND_WRITE;
		seq_addr   = '0;
		seq_data   = '0;
		seq_status = ST_DONE;
		seq_hdata  = '0;
		seq_last   = 1'b0;
		case (head_job.op)
			OP_PROGRAM: begin
				case (step_q)
					3'd0: begin seq_addr = UNLOCK_ADDR_A; seq_data = BYTE_UNLOCK_A; end
					3'd1: begin seq_addr = UNLOCK_ADDR_B; seq_data = BYTE_UNLOCK_B; end
					3'd2: begin seq_addr = UNLOCK_ADDR_A; seq_data = BYTE_PROGRAM; end
					3'd3: begin seq_addr = head_job.addr; seq_data = head_job.data; end
					default: begin
						seq_kind = KIND_READ;
						seq_addr = head_job.addr;
						seq_last = 1'b1;
					end
				endcase
			end
			OP_ERASE: begin
				case (step_q)
					3'd0, 3'd3: begin seq_addr = UNLOCK_ADDR_A; seq_data = BYTE_UNLOCK_A; end
					3'd1, 3'd4: begin seq_addr = UNLOCK_ADDR_B; seq_data = BYTE_UNLOCK_B; end
					3'd2: begin seq_addr = UNLOCK_ADDR_A; seq_data = BYTE_ERASE; end
					3'd5: begin seq_addr = UNLOCK_ADDR_A; seq_data = BYTE_CHIP_ERS; end
					default: begin
						seq_kind = KIND_READ;
						seq_addr = head_job.addr;
						seq_last = 1'b1;
					end
				endcase
			end
			OP_ID_ENTRY: begin
				case (step_q)
					3'd0: begin seq_addr = UNLOCK_ADDR_A; seq_data = BYTE_UNLOCK_A; end
					3'd1: begin seq_addr = UNLOCK_ADDR_B; seq_data = BYTE_UNLOCK_B; end
					3'd2: begin seq_addr = UNLOCK_ADDR_A; seq_data = BYTE_ID_ENTRY; end
					default: begin
						seq_kind = KIND_READ;
						seq_addr = head_job.addr;
						seq_last = 1'b1;
					end
				endcase
			end
			OP_ID_EXIT: begin
				case (step_q)
					3'd0: begin seq_addr = UNLOCK_ADDR_A; seq_data = BYTE_UNLOCK_A; end
					3'd1: begin seq_addr = UNLOCK_ADDR_B; seq_data = BYTE_UNLOCK_B; end
					3'd2: begin seq_addr = UNLOCK_ADDR_A; seq_data = BYTE_ID_EXIT; end
					default: begin
						seq_kind   = KIND_REPORT;
						seq_status = head_job.status;
						seq_hdata  = head_job.hdata;
						seq_last   = 1'b1;
					end
				endcase
			end
			OP_READ: begin
				seq_kind = KIND_READ;
				seq_addr = head_job.addr;
				seq_last = 1'b1;
			end
			default: begin
				seq_kind   = KIND_REPORT;
				seq_status = head_job.status;
				seq_hdata  = head_job.hdata;
				seq_last   = 1'b1;
			end
		endcase
	end

	assign load = head_valid && (!valid_q || rsp.ready);
	assign pop  = load && seq_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				step_q  <= seq_last ? 3'd0 : step_q + 3'd1;
				valid_q <= 1'b1;
			end else if (rsp.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q   <= seq_kind;
			addr_q   <= seq_addr;
			data_q   <= seq_data;
			status_q <= seq_status;
			hdata_q  <= seq_hdata;
			last_q   <= seq_last;
		end
	end

	assign rsp.valid       = valid_q;
	assign rsp.kind        = kind_q;
	assign rsp.bus_address = addr_q;
	assign rsp.bus_data    = data_q;
	assign rsp.status      = status_q;
	assign rsp.host_data   = hdata_q;
	assign rsp.last        = last_q;

	// mid-sequence the job must still be at the queue head
	a_step_has_job: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q != 3'd0) |-> head_valid)
		else $error("sequence step without a job");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= 3'd6)
		else $error("sequence step out of range");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the NOR flash command sequencer: directed and random traffic.
module tb_top;
	import nfcs_pkg::*;

	localparam int CLK_HALF     = 4;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 20;     // well over the longest result sequence of one item
	localparam int RANDOM_ITEMS = 340;
	localparam int MAX_PRINTED  = 20;

	// sequencer phase as tracked by the predictor
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_PROG,
		PH_ERASE,
		PH_ID1,
		PH_ID2,
		PH_READ
	} flash_phase_t;

	typedef struct packed {
		kind_t               kind;
		logic [ADDR_W-1:0]   bus_address;
		logic [DATA_W-1:0]   bus_data;
		status_t             status;
		logic [HDATA_W-1:0]  host_data;
		logic                last;
	} bus_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [PADDR_W-1:0]   paddr;
	logic [PDATA_W-1:0]   pwdata;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;

	nfcs_req_if req_ch();
	nfcs_rsp_if rsp_ch();

	nor_flash_command_sequencer u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// predictor copy of the register and sequencer state
	logic [PL_W-1:0]    poll_limit_q;
	flash_phase_t       phase_q;
	logic [PL_W-1:0]    polls_left_q;
	logic [ADDR_W-1:0]  poll_addr_q;
	logic               top_bit_q;
	logic [DATA_W-1:0]  id_byte_q;

	bus_result_t pending_results[$];  // bus cycles and reports still to come, oldest first
	bus_result_t item_results[$];     // built up for the item being predicted

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int errors        = 0;
	int items_sent    = 0;
	int items_acted   = 0;
	int results_seen  = 0;
	int cycles        = 0;
	int status_seen[4];

	always #CLK_HALF clk = ~clk;

	task automatic report_mismatch(string msg);
		errors++;
		if (errors <= MAX_PRINTED)
			$display("MISMATCH: %s", msg);
	endtask

	// ---------------------------------------------------------------- predictor

	function automatic void add_result(kind_t k, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d,
		status_t s, logic [HDATA_W-1:0] h);
		bus_result_t r;
		r.kind        = k;
		r.bus_address = a;
		r.bus_data    = d;
		r.status      = s;
		r.host_data   = h;
		r.last        = 1'b0;
		item_results.push_back(r);
	endfunction

	function automatic void add_unlock();
		add_result(KIND_WRITE, UNLOCK_ADDR_A, BYTE_UNLOCK_A, ST_DONE, '0);
		add_result(KIND_WRITE, UNLOCK_ADDR_B, BYTE_UNLOCK_B, ST_DONE, '0);
	endfunction

	// a limit of zero still allows one status read
	function automatic void begin_poll(logic [ADDR_W-1:0] a, logic top);
		poll_addr_q  = a;
		top_bit_q    = top;
		polls_left_q = (poll_limit_q == '0) ? PL_W'(1) : poll_limit_q;
		add_result(KIND_READ, a, '0, ST_DONE, '0);
	endfunction

	// Works out the bus cycles and reports one accepted item causes and queues them.
	function automatic int sequence_item(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr,
		logic [DATA_W-1:0] data);
		item_results.delete();
		if (cmd == CMD_RETURN) begin
			case (phase_q)
				PH_PROG, PH_ERASE: begin
					if (data[7] == top_bit_q) begin
						add_result(KIND_REPORT, '0, '0, ST_DONE, '0);
						phase_q = PH_IDLE;
					end else if (polls_left_q <= 1) begin
						polls_left_q = '0;
						add_result(KIND_REPORT, '0, '0, ST_TIMEOUT, '0);
						phase_q = PH_IDLE;
					end else begin
						polls_left_q = polls_left_q - 1'b1;
						add_result(KIND_READ, poll_addr_q, '0, ST_DONE, '0);
					end
				end
				PH_ID1: begin
					id_byte_q = data;
					add_result(KIND_READ, ADDR_W'(1), '0, ST_DONE, '0);
					phase_q = PH_ID2;
				end
				PH_ID2: begin
					// id exit, then hand both id bytes to the host
					add_unlock();
					add_result(KIND_WRITE, UNLOCK_ADDR_A, BYTE_ID_EXIT, ST_DONE, '0);
					add_result(KIND_REPORT, '0, '0, ST_DATA, {id_byte_q, data});
					phase_q = PH_IDLE;
				end
				PH_READ: begin
					add_result(KIND_REPORT, '0, '0, ST_DATA, HDATA_W'(data));
					phase_q = PH_IDLE;
				end
				default: ;  // stray return while idle
			endcase
		end else if (phase_q == PH_IDLE) begin
			case (cmd)
				CMD_PROGRAM: begin
					if (data == BYTE_ERASED) begin
						add_result(KIND_REPORT, '0, '0, ST_SKIPPED, '0);
					end else begin
						add_unlock();
						add_result(KIND_WRITE, UNLOCK_ADDR_A, BYTE_PROGRAM, ST_DONE, '0);
						add_result(KIND_WRITE, addr, data, ST_DONE, '0);
						begin_poll(addr, data[7]);
						phase_q = PH_PROG;
					end
				end
				CMD_ERASE: begin
					add_unlock();
					add_result(KIND_WRITE, UNLOCK_ADDR_A, BYTE_ERASE, ST_DONE, '0);
					add_unlock();
					add_result(KIND_WRITE, UNLOCK_ADDR_A, BYTE_CHIP_ERS, ST_DONE, '0);
					begin_poll('0, 1'b1);
					phase_q = PH_ERASE;
				end
				CMD_READ_ID: begin
					add_unlock();
					add_result(KIND_WRITE, UNLOCK_ADDR_A, BYTE_ID_ENTRY, ST_DONE, '0);
					add_result(KIND_READ, '0, '0, ST_DONE, '0);
					phase_q = PH_ID1;
				end
				CMD_READ: begin
					add_result(KIND_READ, addr, '0, ST_DONE, '0);
					phase_q = PH_READ;
				end
				default: ;  // unknown command codes are dropped
			endcase
		end
		// commands while busy fall through with no result

		if (item_results.size() > 0)
			item_results[item_results.size()-1].last = 1'b1;
		foreach (item_results[i])
			pending_results.push_back(item_results[i]);
		return item_results.size();
	endfunction

	// ---------------------------------------------------------------- drivers

	// Called at a falling edge; returns at the falling edge after the transfer with valid
	// still high, so the next call either keeps it up or drops it for a gap.
	task automatic send_item(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr,
		logic [DATA_W-1:0] data);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.command <= cmd;
		req_ch.address <= addr;
		req_ch.data    <= data;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		items_sent++;
		if (sequence_item(cmd, addr, data) > 0)
			items_acted++;
		@(negedge clk);
	endtask

	// Drop valid, wait for every expected result, then let the pipe run dry.
	task automatic settle();
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic check_poll_limit();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {REG_POLL_LIMIT, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== PDATA_W'(poll_limit_q))
			report_mismatch($sformatf("poll_limit read 0x%0h, expected 0x%0h",
				prdata, poll_limit_q));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Only called with the sequencer idle and nothing outstanding.
	task automatic set_poll_limit(logic [PDATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_POLL_LIMIT, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		poll_limit_q = value[PL_W-1:0];  // upper bits are not stored
		@(negedge clk);
		check_poll_limit();
	endtask

	// receiver stalls
	always @(negedge clk)
		rsp_ch.ready <= ($urandom_range(99) >= stall_pct);

	// ---------------------------------------------------------------- checker

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d: %s is 0x%0h, expected 0x%0h",
				results_seen, name, got, want));
	endtask

	always @(posedge clk) begin
		bus_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result: kind %0d addr 0x%0h data 0x%0h",
					rsp_ch.kind, rsp_ch.bus_address, rsp_ch.bus_data));
			end else begin
				want = pending_results.pop_front();
				check_field("kind", 32'(rsp_ch.kind), 32'(want.kind));
				check_field("bus_address", 32'(rsp_ch.bus_address), 32'(want.bus_address));
				check_field("bus_data", 32'(rsp_ch.bus_data), 32'(want.bus_data));
				check_field("status", 32'(rsp_ch.status), 32'(want.status));
				check_field("host_data", 32'(rsp_ch.host_data), 32'(want.host_data));
				check_field("last", 32'(rsp_ch.last), 32'(want.last));
				if (want.kind == KIND_REPORT)
					status_seen[want.status]++;
			end
			results_seen++;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, pending_results.size());
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// ---------------------------------------------------------------- tests

	// Every command at the reset poll limit, erased-byte skip, busy, stray and unknown items.
	task automatic test_directed_commands();
		check_poll_limit();
		send_item(CMD_PROGRAM, 19'h00000, 8'h00);
		send_item(CMD_READ, 19'h12345, 8'h00);           // busy, dropped
		send_item(CMD_RETURN, 19'h00000, 8'h80);         // bit 7 wrong, poll again
		send_item(CMD_RETURN, 19'h7FFFF, 8'h00);         // done
		send_item(CMD_PROGRAM, 19'h7FFFF, BYTE_ERASED);  // skipped
		send_item(CMD_PROGRAM, 19'h2AAAA, 8'h80);
		send_item(CMD_RETURN, 19'h55555, 8'h7F);
		send_item(CMD_RETURN, 19'h00000, 8'hFF);
		send_item(CMD_ERASE, 19'h7FFFF, 8'hFF);
		send_item(CMD_RETURN, 19'h00000, 8'h00);
		send_item(CMD_RETURN, 19'h00000, 8'h7F);
		send_item(CMD_RETURN, 19'h00000, 8'h80);
		send_item(CMD_RETURN, 19'h7FFFF, 8'hFF);         // stray, idle
		send_item(3'd5, 19'h7FFFF, 8'hFF);
		send_item(3'd6, 19'h00000, 8'h00);
		send_item(3'd7, 19'h7FFFF, 8'hFF);
		send_item(CMD_READ_ID, 19'h7FFFF, 8'hFF);
		send_item(CMD_RETURN, 19'h00000, 8'hBF);
		send_item(CMD_PROGRAM, 19'h00001, 8'h12);        // busy, dropped
		send_item(CMD_RETURN, 19'h00001, 8'hD7);
		send_item(CMD_READ, 19'h7FFFF, 8'h00);
		send_item(CMD_RETURN, 19'h00000, 8'hA5);
		send_item(CMD_READ, 19'h00000, 8'hFF);
		send_item(CMD_RETURN, 19'h7FFFF, 8'h5A);
		settle();
	endtask

	// Timeout paths at small limits, zero treated as one, and the top of the range.
	task automatic test_poll_limits();
		set_poll_limit(32'd1);
		send_item(CMD_PROGRAM, 19'h0ABCD, 8'h80);
		send_item(CMD_RETURN, 19'h0ABCD, 8'h00);         // timeout on first read
		settle();
		set_poll_limit(32'd0);
		send_item(CMD_ERASE, 19'h00000, 8'h00);
		send_item(CMD_RETURN, 19'h00000, 8'h55);         // timeout on first read
		settle();
		set_poll_limit(32'hFFFF_C003);                   // stored as 3
		send_item(CMD_PROGRAM, 19'h40000, 8'h3C);
		send_item(CMD_RETURN, 19'h00000, 8'h80);
		send_item(CMD_RETURN, 19'h00000, 8'h80);
		send_item(CMD_RETURN, 19'h00000, 8'h80);         // timeout on third read
		settle();
		set_poll_limit(32'd16383);
		send_item(CMD_ERASE, 19'h12345, 8'h00);
		send_item(CMD_RETURN, 19'h00000, 8'h00);
		send_item(CMD_RETURN, 19'h00000, 8'h01);
		send_item(CMD_RETURN, 19'h00000, 8'h7F);
		send_item(CMD_RETURN, 19'h00000, 8'h80);
		settle();
	endtask

	// One host command with its flash returns; sometimes noise or a broken-off sequence.
	task automatic run_flash_sequence();
		logic [DATA_W-1:0] d;
		int misses;
		int polls;
		if ($urandom_range(99) < 12) begin
			send_item(CMD_W'($urandom_range(7)), ADDR_W'($urandom), DATA_W'($urandom));
			return;
		end
		case ($urandom_range(3))
			0: begin
				d = ($urandom_range(7) == 0) ? BYTE_ERASED : DATA_W'($urandom);
				send_item(CMD_PROGRAM, ADDR_W'($urandom), d);
			end
			1: send_item(CMD_ERASE, ADDR_W'($urandom), DATA_W'($urandom));
			2: send_item(CMD_READ_ID, ADDR_W'($urandom), DATA_W'($urandom));
			default: send_item(CMD_READ, ADDR_W'($urandom), DATA_W'($urandom));
		endcase
		misses = $urandom_range(6);
		polls  = 0;
		while (phase_q != PH_IDLE) begin
			if ($urandom_range(29) == 0)
				break;  // abandon; the next command lands while busy
			if ($urandom_range(9) == 0) begin
				// host command while busy, or an unknown code
				if ($urandom_range(1))
					send_item(CMD_W'($urandom_range(3)), ADDR_W'($urandom),
						DATA_W'($urandom));
				else
					send_item(CMD_W'($urandom_range(5, 7)), ADDR_W'($urandom),
						DATA_W'($urandom));
			end else if (phase_q == PH_PROG || phase_q == PH_ERASE) begin
				d    = DATA_W'($urandom);
				d[7] = (polls < misses) ? ~top_bit_q : top_bit_q;
				send_item(CMD_RETURN, ADDR_W'($urandom), d);
				polls++;
			end else begin
				send_item(CMD_RETURN, ADDR_W'($urandom), DATA_W'($urandom));
			end
		end
	endtask

	task automatic test_random(int idle_pct, int stall, logic [PDATA_W-1:0] limit);
		int goal;
		logic [DATA_W-1:0] d;
		settle();
		send_idle_pct = idle_pct;
		stall_pct     = stall;
		set_poll_limit(limit);
		goal = items_sent + RANDOM_ITEMS / 4;
		while (items_sent < goal)
			run_flash_sequence();
		// finish whatever is still open so the next register write sees an idle block
		while (phase_q != PH_IDLE) begin
			d    = DATA_W'($urandom);
			d[7] = top_bit_q;
			send_item(CMD_RETURN, ADDR_W'($urandom), d);
		end
		settle();
	endtask

	initial begin
		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		req_ch.valid   = 1'b0;
		req_ch.command = '0;
		req_ch.address = '0;
		req_ch.data    = '0;
		rsp_ch.ready   = 1'b1;
		foreach (status_seen[i])
			status_seen[i] = 0;

		poll_limit_q = POLL_LIMIT_RESET;
		phase_q      = PH_IDLE;
		polls_left_q = '0;
		poll_addr_q  = '0;
		top_bit_q    = 1'b0;
		id_byte_q    = '0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_commands();
		test_poll_limits();
		test_random(0, 0, 32'd5);
		test_random(53, 0, 32'd1);
		test_random(0, 53, 32'd16383);
		test_random(6, 6, 32'd2);

		$display("%0d items sent (%0d acted on), %0d results checked, poll limits 0 to 16383",
			items_sent, items_acted, results_seen);
		$display("reports: %0d done, %0d timeout, %0d skipped, %0d data",
			status_seen[ST_DONE], status_seen[ST_TIMEOUT], status_seen[ST_SKIPPED],
			status_seen[ST_DATA]);
		if (errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

/* filelist.f */
src/nfcs_pkg.sv
src/nfcs_if.sv
src/nfcs_front.sv
src/nfcs_queue.sv
src/nfcs_back.sv
src/nor_flash_command_sequencer.sv
sim/tb_top.sv
